>>> rtl/core/scba_pkg.sv
package scba_pkg;

    localparam int NUM_PAGES = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int PG_W = $clog2(NUM_PAGES);
    localparam int PL_W = $clog2(NUM_PAGES + 1);
    localparam int SLOT_W = 7;
    localparam int BA_W = PG_W + SLOT_W;
    localparam int ADDR_W = 18;
    localparam int OFF_W = 12;
    localparam int LEN_W = 12;
    localparam int NCLASS = 8;
    localparam int CLS_W = 3;
    localparam int DESC_BYTES = 16;
    localparam int HDR_BYTES = 8;
    localparam int MAX_REQ = 2048;

    localparam logic [PL_W-1:0] PG_NULL = PL_W'(NUM_PAGES);
    localparam logic [SLOT_W-1:0] BLK_NULL = 7'd127;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE = 2'd1;
    localparam logic [1:0] FN_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_NO_PAGE = 2'd2;

    typedef struct packed {
        logic taken;
        logic [CLS_W-1:0] cls;
        logic [SLOT_W-1:0] cnt;
        logic [PL_W-1:0] nxt;
        logic [SLOT_W-1:0] ff;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    function automatic logic [OFF_W-1:0] class_size(input logic [CLS_W-1:0] c);
        logic [OFF_W-1:0] r;
        case (c)
            3'd0: r = 12'd32;
            3'd1: r = 12'd64;
            3'd2: r = 12'd128;
            3'd3: r = 12'd252;
            3'd4: r = 12'd508;
            3'd5: r = 12'd1020;
            3'd6: r = 12'd2040;
            default: r = 12'd4080;
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] class_blocks(input logic [CLS_W-1:0] c);
        logic [SLOT_W-1:0] r;
        case (c)
            3'd0: r = 7'd127;
            3'd1: r = 7'd63;
            3'd2: r = 7'd31;
            3'd3: r = 7'd16;
            3'd4: r = 7'd8;
            3'd5: r = 7'd4;
            3'd6: r = 7'd2;
            default: r = 7'd1;
        endcase
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] class_of(input logic [LEN_W-1:0] req);
        logic [CLS_W-1:0] c;
        logic [LEN_W:0] need;
        c = '0;
        need = {1'b0, req} + (LEN_W + 1)'(HDR_BYTES);
        for (int i = 0; i < NCLASS - 1; i++)
        begin
            if (c == CLS_W'(i) && need > {1'b0, class_size(CLS_W'(i))})
            begin
                c = CLS_W'(i + 1);
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/scba_ram.sv
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/size_class_block_allocator.sv
// channel   direction  handshake          payload
// request   in         start & !busy      func, req_size, obj_addr
// result    out        done (one cycle)   addr, length, status
//
// Allocate from a listed page, or else scan the pool for an untaken page and carve it:
// the carve links every block of the class (up to 127) into the page's free list.
// Free and query find the slot by a 7-step slot divide; a free that makes a page wholly
// free releases it, unlinking it from its class list by a walk if it is not the head.
// Reset: page descriptors read as empty through per-page valid flops, no clear pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module size_class_block_allocator
    import scba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [LEN_W-1:0]    req_size,
    input  logic [ADDR_W-1:0]   obj_addr,
    output logic                done,
    output logic [ADDR_W-1:0]   addr,
    output logic [LEN_W-1:0]    length,
    output logic [1:0]          status
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ACK = 5'd1;
    localparam logic [4:0] S_SRD = 5'd2;
    localparam logic [4:0] S_SCK = 5'd3;
    localparam logic [4:0] S_CARVE = 5'd4;
    localparam logic [4:0] S_CFIN = 5'd5;
    localparam logic [4:0] S_PRD = 5'd6;
    localparam logic [4:0] S_PUPD = 5'd7;
    localparam logic [4:0] S_PADDR = 5'd8;
    localparam logic [4:0] S_FCK = 5'd9;
    localparam logic [4:0] S_DIV = 5'd10;
    localparam logic [4:0] S_FRNG = 5'd11;
    localparam logic [4:0] S_QRD = 5'd12;
    localparam logic [4:0] S_QWT = 5'd13;
    localparam logic [4:0] S_FUPD = 5'd14;
    localparam logic [4:0] S_WRD = 5'd15;
    localparam logic [4:0] S_WCK = 5'd16;
    localparam logic [4:0] S_REL = 5'd17;

    localparam desc_t DESC_RST = '{taken: 1'b0, cls: '0, cnt: '0, nxt: PG_NULL, ff: BLK_NULL};

    logic [4:0] state_reg, state_next;
    logic [1:0] func_reg, func_next;
    logic [LEN_W-1:0] req_reg, req_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [CLS_W-1:0] c_reg, c_next;
    logic [PL_W-1:0] p_reg, p_next;
    desc_t d_reg, d_next;
    logic [PL_W-1:0] i_reg, i_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [OFF_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0] q_reg, q_next;
    logic [2:0] dk_reg, dk_next;
    logic [PL_W-1:0] cur_reg, cur_next;
    logic [PL_W-1:0] steps_reg, steps_next;
    logic [PL_W-1:0] pnext_reg, pnext_next;
    logic [OFF_W-1:0] prod_reg, prod_next;
    logic [PL_W-1:0] head_reg [NCLASS];
    logic [PL_W-1:0] head_next [NCLASS];
    logic [NUM_PAGES-1:0] pv_reg, pv_next;
    logic pvq_reg;
    logic done_reg, done_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [1:0] status_reg, status_next;

    logic pwe;
    logic [PG_W-1:0] pwaddr, praddr;
    desc_t pwdata, desc_rd;
    logic [DESC_W-1:0] pram_q;

    logic lwe;
    logic [BA_W-1:0] lwaddr, lraddr;
    logic [SLOT_W-1:0] lwdata, lram_q;

    logic bwe;
    logic [BA_W-1:0] bwaddr, braddr;
    logic [LEN_W-1:0] bram_q;

    scba_ram #(.WIDTH(DESC_W), .DEPTH(NUM_PAGES)) u_page_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwaddr),
        .wdata (pwdata),
        .raddr (praddr),
        .rdata (pram_q)
    );

    scba_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_PAGES * 128)) u_link_ram (
        .clk   (clk),
        .we    (lwe),
        .waddr (lwaddr),
        .wdata (lwdata),
        .raddr (lraddr),
        .rdata (lram_q)
    );

    scba_ram #(.WIDTH(LEN_W), .DEPTH(NUM_PAGES * 128)) u_len_ram (
        .clk   (clk),
        .we    (bwe),
        .waddr (bwaddr),
        .wdata (req_reg),
        .raddr (braddr),
        .rdata (bram_q)
    );

    assign desc_rd = pvq_reg ? desc_t'(pram_q) : DESC_RST;

    logic [CLS_W-1:0] in_cls;
    logic [PL_W-1:0] obj_pg;
    logic [OFF_W-1:0] csize;
    logic [SLOT_W-1:0] cblocks;
    logic [ADDR_W:0] sz_sh;
    logic [SLOT_W:0] n8;
    desc_t nd;
    logic [PL_W-1:0] head_after;

    assign in_cls = class_of(req_size);
    assign obj_pg = PL_W'(obj_addr[ADDR_W-1:12]);
    assign csize = class_size(c_reg);
    assign cblocks = class_blocks(c_reg);
    assign sz_sh = (ADDR_W + 1)'(csize) << dk_reg;

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        req_next = req_reg;
        off_next = off_reg;
        c_next = c_reg;
        p_next = p_reg;
        d_next = d_reg;
        i_next = i_reg;
        k_next = k_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        dk_next = dk_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        pnext_next = pnext_reg;
        prod_next = prod_reg;
        head_next = head_reg;
        pv_next = pv_reg;
        done_next = 1'b0;
        addr_next = addr_reg;
        length_next = length_reg;
        status_next = status_reg;
        pwe = 1'b0;
        pwaddr = p_reg[PG_W-1:0];
        pwdata = d_reg;
        praddr = p_reg[PG_W-1:0];
        lwe = 1'b0;
        lwaddr = {p_reg[PG_W-1:0], q_reg};
        lwdata = d_reg.ff;
        lraddr = {p_reg[PG_W-1:0], d_reg.ff};
        bwe = 1'b0;
        bwaddr = {p_reg[PG_W-1:0], q_reg};
        braddr = {p_reg[PG_W-1:0], q_reg};
        nd = d_reg;
        n8 = '0;
        head_after = head_reg[c_reg];

        case (state_reg)
            S_IDLE:
            begin
                func_next = func;
                req_next = req_size;
                off_next = obj_addr[OFF_W-1:0];
                addr_next = '0;
                length_next = '0;
                status_next = ST_OK;
                if (start)
                begin
                    if (func == FN_ALLOC)
                    begin
                        c_next = in_cls;
                        p_next = head_reg[in_cls];
                        praddr = head_reg[in_cls][PG_W-1:0];
                        i_next = '0;
                        if (req_size > LEN_W'(MAX_REQ))
                        begin
                            status_next = ST_TOO_BIG;
                            done_next = 1'b1;
                        end
                        else if (head_reg[in_cls] < PG_NULL)
                        begin
                            state_next = S_ACK;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                    else if (func == FN_FREE || func == FN_QUERY)
                    begin
                        p_next = obj_pg;
                        praddr = obj_pg[PG_W-1:0];
                        if (obj_pg < PG_NULL)
                        begin
                            state_next = S_FCK;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_ACK:
            begin
                d_next = desc_rd;
                state_next = (desc_rd.ff == BLK_NULL) ? S_SRD : S_PRD;
            end
            S_SRD:
            begin
                praddr = i_reg[PG_W-1:0];
                if (i_reg >= PG_NULL)
                begin
                    status_next = ST_NO_PAGE;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCK;
                end
            end
            S_SCK:
            begin
                if (!desc_rd.taken)
                begin
                    p_next = i_reg;
                    k_next = '0;
                    state_next = S_CARVE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_CARVE:
            begin
                lwe = 1'b1;
                lwaddr = {p_reg[PG_W-1:0], k_reg};
                lwdata = (k_reg + 1'b1 == cblocks) ? BLK_NULL : k_reg + 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == cblocks)
                begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN:
            begin
                nd = '{taken: 1'b1, cls: c_reg, cnt: cblocks, nxt: head_reg[c_reg], ff: '0};
                d_next = nd;
                pwe = 1'b1;
                pwdata = nd;
                head_next[c_reg] = p_reg;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                q_next = d_reg.ff;
                state_next = S_PUPD;
            end
            S_PUPD:
            begin
                nd.ff = lram_q;
                nd.cnt = (d_reg.cnt != '0) ? d_reg.cnt - 1'b1 : '0;
                if (nd.cnt == '0)
                begin
                    head_next[c_reg] = d_reg.nxt;
                    nd.nxt = PG_NULL;
                end
                pwe = 1'b1;
                pwdata = nd;
                bwe = 1'b1;
                prod_next = OFF_W'(q_reg * csize);
                state_next = S_PADDR;
            end
            S_PADDR:
            begin
                addr_next = (ADDR_W'(p_reg) << 12) + ADDR_W'(DESC_BYTES + HDR_BYTES)
                    + ADDR_W'(prod_reg);
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_FCK:
            begin
                d_next = desc_rd;
                c_next = desc_rd.cls;
                rem_next = off_reg - OFF_W'(DESC_BYTES + HDR_BYTES);
                q_next = '0;
                dk_next = 3'd6;
                if (!desc_rd.taken || off_reg < OFF_W'(DESC_BYTES + HDR_BYTES))
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if ((ADDR_W + 1)'(rem_reg) >= sz_sh)
                begin
                    rem_next = rem_reg - OFF_W'(sz_sh);
                    q_next = q_reg | (SLOT_W'(1) << dk_reg);
                end
                dk_next = dk_reg - 1'b1;
                if (dk_reg == 3'd0)
                begin
                    state_next = S_FRNG;
                end
            end
            S_FRNG:
            begin
                if (q_reg >= cblocks)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (func_reg == FN_QUERY) ? S_QRD : S_FUPD;
                end
            end
            S_QRD:
            begin
                state_next = S_QWT;
            end
            S_QWT:
            begin
                length_next = bram_q;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_FUPD:
            begin
                lwe = 1'b1;
                n8 = {1'b0, d_reg.cnt} + 1'b1;
                nd.ff = q_reg;
                nd.cnt = n8[SLOT_W-1:0];
                if (n8 == 8'd1)
                begin
                    nd.nxt = head_reg[c_reg];
                    head_after = p_reg;
                end
                pwe = 1'b1;
                pwdata = nd;
                d_next = nd;
                pnext_next = nd.nxt;
                cur_next = head_after;
                steps_next = '0;
                head_next[c_reg] = head_after;
                if (n8 >= {1'b0, cblocks})
                begin
                    if (head_after == p_reg)
                    begin
                        head_next[c_reg] = nd.nxt;
                        state_next = S_REL;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WRD:
            begin
                praddr = cur_reg[PG_W-1:0];
                state_next = (cur_reg >= PG_NULL) ? S_REL : S_WCK;
            end
            S_WCK:
            begin
                if (desc_rd.nxt == p_reg)
                begin
                    nd = desc_rd;
                    nd.nxt = pnext_reg;
                    pwe = 1'b1;
                    pwaddr = cur_reg[PG_W-1:0];
                    pwdata = nd;
                    state_next = S_REL;
                end
                else if (steps_reg >= PL_W'(NUM_PAGES))
                begin
                    state_next = S_REL;
                end
                else
                begin
                    cur_next = desc_rd.nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_REL:
            begin
                nd = DESC_RST;
                nd.cls = c_reg;
                pwe = 1'b1;
                pwdata = nd;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pwe)
        begin
            pv_next[pwaddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            pv_reg <= '0;
            pvq_reg <= 1'b0;
            for (int j = 0; j < NCLASS; j++)
            begin
                head_reg[j] <= PG_NULL;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            pv_reg <= pv_next;
            pvq_reg <= pv_reg[praddr];
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        req_reg <= req_next;
        off_reg <= off_next;
        c_reg <= c_next;
        p_reg <= p_next;
        d_reg <= d_next;
        i_reg <= i_next;
        k_reg <= k_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        dk_reg <= dk_next;
        cur_reg <= cur_next;
        steps_reg <= steps_next;
        pnext_reg <= pnext_next;
        prod_reg <= prod_next;
        addr_reg <= addr_next;
        length_reg <= length_next;
        status_reg <= status_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign addr = addr_reg;
    assign length = length_reg;
    assign status = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without an accepted item");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (addr == '0 && length == '0))
        else $error("error result carries data");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FUPD || state_reg == S_QRD) |-> (q_reg < cblocks))
        else $error("slot beyond class block count");

endmodule

>>> dv/size_class_block_allocator_tb.sv
module size_class_block_allocator_tb;
    import scba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FN_NONE = 2'd3;
    localparam int SLOTS = 128;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [1:0] st;
    } alloc_result_t;

    typedef struct packed {
        logic [1:0] fn;
        logic [LEN_W-1:0] req;
        logic [ADDR_W-1:0] obj;
        logic fixed;
        alloc_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] func;
    logic [LEN_W-1:0] req_size;
    logic [ADDR_W-1:0] obj_addr;
    logic done;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0] length;
    logic [1:0] status;

    int blk_bytes[NCLASS] = '{32, 64, 128, 252, 508, 1020, 2040, 4080};
    int blk_count[NCLASS] = '{127, 63, 31, 16, 8, 4, 2, 1};

    logic [PL_W-1:0] head_page[NCLASS];
    logic pg_taken[NUM_PAGES];
    logic [CLS_W-1:0] pg_cls[NUM_PAGES];
    logic [SLOT_W-1:0] pg_cnt[NUM_PAGES];
    logic [PL_W-1:0] pg_next[NUM_PAGES];
    logic [SLOT_W-1:0] pg_first[NUM_PAGES];
    logic [SLOT_W-1:0] blk_next[NUM_PAGES*SLOTS];
    logic [LEN_W-1:0] blk_len[NUM_PAGES*SLOTS];
    bit blk_written[NUM_PAGES*SLOTS];

    alloc_result_t pending_results[$];
    logic [ADDR_W-1:0] live_blocks[$];
    int mismatches;
    int items_sent;
    int results_seen;
    int no_page_seen;
    int idle_cycles;

    size_class_block_allocator u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .req_size(req_size),
        .obj_addr(obj_addr),
        .done(done),
        .addr(addr),
        .length(length),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic bit decode_block(input logic [ADDR_W-1:0] a, output int pg,
                                        output int sl);
        int off;
        int c;
        pg = int'(a >> 12);
        off = int'(a & 18'hFFF);
        sl = 0;
        if (pg >= NUM_PAGES || !pg_taken[pg] || off < DESC_BYTES + HDR_BYTES)
            return 0;
        c = int'(pg_cls[pg]);
        sl = (off - DESC_BYTES - HDR_BYTES) / blk_bytes[c];
        return sl < blk_count[c];
    endfunction

    function automatic void release_block(input logic [ADDR_W-1:0] a);
        int p;
        int s;
        int c;
        int n;
        int cur;
        int steps;
        if (!decode_block(a, p, s))
            return;
        c = int'(pg_cls[p]);
        blk_next[p*SLOTS+s] = pg_first[p];
        pg_first[p] = SLOT_W'(s);
        n = int'(pg_cnt[p]) + 1;
        pg_cnt[p] = SLOT_W'(n);
        if (n == 1)
        begin
            pg_next[p] = head_page[c];
            head_page[c] = PL_W'(p);
        end
        if (n >= blk_count[c])
        begin
            if (int'(head_page[c]) == p)
                head_page[c] = pg_next[p];
            else
            begin
                cur = int'(head_page[c]);
                steps = 0;
                while (cur < NUM_PAGES && int'(pg_next[cur]) != p && steps < NUM_PAGES)
                begin
                    cur = int'(pg_next[cur]);
                    steps++;
                end
                if (cur < NUM_PAGES && int'(pg_next[cur]) == p)
                    pg_next[cur] = pg_next[p];
            end
            pg_taken[p] = 1'b0;
            pg_next[p] = PG_NULL;
            pg_cnt[p] = '0;
            pg_first[p] = BLK_NULL;
        end
    endfunction

    function automatic alloc_result_t grab_block(input logic [LEN_W-1:0] req);
        alloc_result_t r;
        int c;
        int p;
        int s;
        r = '0;
        if (int'(req) > MAX_REQ)
        begin
            r.st = ST_TOO_BIG;
            return r;
        end
        c = 0;
        while (c < NCLASS - 1 && int'(req) + HDR_BYTES > blk_bytes[c])
            c++;
        p = int'(head_page[c]);
        if (p >= NUM_PAGES || pg_first[p] == BLK_NULL)
        begin
            for (p = 0; p < NUM_PAGES && pg_taken[p]; p++)
                ;
            if (p >= NUM_PAGES)
            begin
                r.st = ST_NO_PAGE;
                return r;
            end
            for (int k = 0; k + 1 < blk_count[c]; k++)
                blk_next[p*SLOTS+k] = SLOT_W'(k + 1);
            blk_next[p*SLOTS+blk_count[c]-1] = BLK_NULL;
            pg_taken[p] = 1'b1;
            pg_cls[p] = CLS_W'(c);
            pg_cnt[p] = SLOT_W'(blk_count[c]);
            pg_first[p] = '0;
            pg_next[p] = head_page[c];
            head_page[c] = PL_W'(p);
        end
        s = int'(pg_first[p]);
        pg_first[p] = blk_next[p*SLOTS+s];
        if (pg_cnt[p] > 0)
            pg_cnt[p] = pg_cnt[p] - 1'b1;
        if (pg_cnt[p] == 0)
        begin
            head_page[c] = pg_next[p];
            pg_next[p] = PG_NULL;
        end
        blk_len[p*SLOTS+s] = req;
        blk_written[p*SLOTS+s] = 1'b1;
        r.addr = ADDR_W'(p * PAGE_BYTES + DESC_BYTES + s * blk_bytes[c] + HDR_BYTES);
        return r;
    endfunction

    function automatic alloc_result_t allocator_predict(input logic [1:0] fn,
                                                        input logic [LEN_W-1:0] req,
                                                        input logic [ADDR_W-1:0] obj);
        alloc_result_t r;
        int p;
        int s;
        r = '0;
        if (fn == FN_ALLOC)
            r = grab_block(req);
        else if (fn == FN_FREE)
            release_block(obj);
        else if (fn == FN_QUERY && decode_block(obj, p, s))
            r.len = blk_len[p*SLOTS+s];
        return r;
    endfunction

    task automatic issue_item(input int gap, input logic [1:0] fn, input logic [LEN_W-1:0] req,
                              input logic [ADDR_W-1:0] obj, input bit fixed,
                              input alloc_result_t fixed_res);
        alloc_result_t r;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func = fn;
        req_size = req;
        obj_addr = obj;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        r = allocator_predict(fn, req, obj);
        if (fixed)
            r = fixed_res;
        pending_results.push_back(r);
        if (fn == FN_ALLOC && r.st == ST_OK)
            live_blocks.push_back(r.addr);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_size();
        int c;
        int lo;
        int hi;
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        lo = (c == 0) ? 0 : blk_bytes[c-1] - HDR_BYTES + 1;
        hi = (c == NCLASS - 1) ? MAX_REQ : blk_bytes[c] - HDR_BYTES;
        case ($urandom_range(0, 3))
            0: return LEN_W'(lo);
            1: return LEN_W'(hi);
            default: return LEN_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] take_live(input bit remove);
        int i;
        logic [ADDR_W-1:0] a;
        i = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[i];
        if (remove)
            live_blocks.delete(i);
        return a;
    endfunction

    // a query must never land on a block whose length was never recorded
    function automatic logic [ADDR_W-1:0] safe_query_addr(input logic [ADDR_W-1:0] a);
        int p;
        int s;
        if (decode_block(a, p, s) && !blk_written[p*SLOTS+s])
            return '0;
        return a;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && done)
        begin
            got.addr = addr;
            got.len = length;
            got.st = status;
            results_seen++;
            if (status == ST_NO_PAGE)
                no_page_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result addr=%0d length=%0d status=%0d",
                             addr, length, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected addr=%0d length=%0d status=%0d",
                                 results_seen, want.addr, want.len, want.st);
                        $display("    got addr=%0d length=%0d status=%0d",
                                 got.addr, got.len, got.st);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    stim_row_t directed[] = '{
        '{FN_QUERY, 12'd0, 18'd0, 1'b1, '{18'd0, 12'd0, ST_OK}},
        '{FN_FREE, 12'd0, 18'h3FFFF, 1'b1, '{18'd0, 12'd0, ST_OK}},
        '{FN_ALLOC, 12'd4095, 18'd0, 1'b1, '{18'd0, 12'd0, ST_TOO_BIG}},
        '{FN_ALLOC, 12'd2049, 18'd0, 1'b1, '{18'd0, 12'd0, ST_TOO_BIG}},
        '{FN_NONE, 12'hFFF, 18'h3FFFF, 1'b1, '{18'd0, 12'd0, ST_OK}},
        '{FN_ALLOC, 12'd0, 18'd0, 1'b1, '{18'd24, 12'd0, ST_OK}},
        '{FN_ALLOC, 12'd2048, 18'd0, 1'b1, '{18'd4120, 12'd0, ST_OK}},
        '{FN_ALLOC, 12'd24, 18'd0, 1'b1, '{18'd56, 12'd0, ST_OK}},
        '{FN_QUERY, 12'd0, 18'd4120, 1'b1, '{18'd0, 12'd2048, ST_OK}},
        '{FN_QUERY, 12'd0, 18'd60, 1'b1, '{18'd0, 12'd24, ST_OK}},
        '{FN_QUERY, 12'd0, 18'd23, 1'b1, '{18'd0, 12'd0, ST_OK}},
        '{FN_ALLOC, 12'd25, 18'd0, 1'b0, '0},
        '{FN_ALLOC, 12'd244, 18'd0, 1'b0, '0},
        '{FN_ALLOC, 12'd1012, 18'd0, 1'b0, '0},
        '{FN_ALLOC, 12'd2032, 18'd0, 1'b0, '0},
        '{FN_FREE, 12'd0, 18'd56, 1'b0, '0},
        '{FN_ALLOC, 12'd7, 18'd0, 1'b0, '0},
        '{FN_FREE, 12'd0, 18'd4120, 1'b0, '0},
        '{FN_QUERY, 12'd0, 18'd4120, 1'b1, '{18'd0, 12'd0, ST_OK}},
        '{FN_FREE, 12'd0, 18'd24, 1'b0, '0},
        '{FN_FREE, 12'd0, 18'd56, 1'b0, '0},
        '{FN_QUERY, 12'd0, 18'd4095, 1'b0, '0}
    };

    initial
    begin
        int roll;
        int n;
        logic [ADDR_W-1:0] a;
        rst_n = 1'b0;
        start = 1'b0;
        func = FN_NONE;
        req_size = '0;
        obj_addr = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        no_page_seen = 0;
        for (int c = 0; c < NCLASS; c++)
            head_page[c] = PG_NULL;
        for (int p = 0; p < NUM_PAGES; p++)
        begin
            pg_taken[p] = 1'b0;
            pg_cls[p] = '0;
            pg_cnt[p] = '0;
            pg_next[p] = PG_NULL;
            pg_first[p] = BLK_NULL;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            issue_item(pick_gap(), directed[i].fn, directed[i].req, directed[i].obj,
                       directed[i].fixed, directed[i].res);
        live_blocks.delete();
        for (int p = 0; p < NUM_PAGES; p++)
            for (int s = 0; s < SLOTS; s++)
                if (pg_taken[p] && blk_written[p*SLOTS+s])
                    live_blocks.push_back(18'd0);
        live_blocks.delete();

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n % 400 == 200)
            begin
                // drain the pool with whole-page blocks, then hand them all back
                for (int k = 0; k < NUM_PAGES + 6; k++)
                    issue_item(pick_gap(), FN_ALLOC, LEN_W'($urandom_range(2033, MAX_REQ)),
                               ADDR_W'($urandom), 1'b0, '0);
                while (live_blocks.size() > 0)
                begin
                    issue_item(pick_gap(), FN_FREE, LEN_W'($urandom), take_live(1'b1),
                               1'b0, '0);
                    n++;
                end
                n += NUM_PAGES + 6;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45 && live_blocks.size() < 300)
                issue_item(pick_gap(), FN_ALLOC, pick_size(), ADDR_W'($urandom), 1'b0, '0);
            else if (roll < 80 && live_blocks.size() > 0)
                issue_item(pick_gap(), FN_FREE, LEN_W'($urandom), take_live(1'b1), 1'b0, '0);
            else if (roll < 93 && live_blocks.size() > 0)
            begin
                a = safe_query_addr(take_live(1'b0));
                issue_item(pick_gap(), FN_QUERY, LEN_W'($urandom), a, 1'b0, '0);
            end
            else
            begin
                a = ADDR_W'($urandom);
                case ($urandom_range(0, 3))
                    0: issue_item(pick_gap(), FN_NONE, LEN_W'($urandom), a, 1'b0, '0);
                    1: issue_item(pick_gap(), FN_ALLOC, LEN_W'($urandom_range(2049, 4095)),
                                  a, 1'b0, '0);
                    2: issue_item(pick_gap(), FN_QUERY, LEN_W'($urandom),
                                  safe_query_addr(a), 1'b0, '0);
                    default: issue_item(pick_gap(), FN_FREE, LEN_W'($urandom), a, 1'b0, '0);
                endcase
            end
            n++;
        end
        start = 1'b0;

        while (pending_results.size() > 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        mismatches += pending_results.size();
        $display("%0d items sent, %0d results checked, %0d of them with the pool exhausted",
                 items_sent, results_seen, no_page_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/scba_pkg.sv
rtl/core/scba_ram.sv
rtl/core/size_class_block_allocator.sv
dv/size_class_block_allocator_tb.sv
